// ----- hw/rtl/tiled_texture_to_linear_argb_macros.svh -----
// Assertion macros shared by the tiled texture to linear ARGB converter.
`ifndef TILED_TEXTURE_TO_LINEAR_ARGB_MACROS_SVH
`define TILED_TEXTURE_TO_LINEAR_ARGB_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTLA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tiled texture converter check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tiled texture converter check failed");

`endif

// ----- hw/rtl/ttla_pkg.sv -----
// Package with types, codes and constants of the tiled texture to linear ARGB converter.
`timescale 1ns / 1ps
package ttla_pkg;

  localparam int MAX_DIM_DEF   = 1024;
  localparam int PAL_DEPTH     = 256;
  localparam int PAL_AW        = 8;
  localparam int PIX_W         = 10;
  localparam int WORD_W        = 16;
  localparam int COLOR_W       = 32;
  localparam int DIM_W         = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int TILE_W_5A3    = 4;
  localparam int TILE_W_CI8    = 8;
  localparam int TILE_H        = 4;

  localparam logic FMT_CI8    = 1'b0;
  localparam logic FMT_RGB5A3 = 1'b1;

  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_TEXEL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd8;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd8;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
  } pos_t;

endpackage

// ----- hw/rtl/ttla_pos.sv -----
// Tile and within-tile position counters that give linear pixel coordinates.
`timescale 1ns / 1ps
module ttla_pos #(
  parameter int MAX_DIM = ttla_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        advance,
  input  logic                        fmt,
  input  logic [ttla_pkg::DIM_W-1:0]  width_tiles,
  input  logic [ttla_pkg::DIM_W-1:0]  height_tiles,
  output ttla_pkg::pos_t              pos
);
  import ttla_pkg::*;

  localparam int TCW  = (MAX_DIM / 4 > 1) ? $clog2(MAX_DIM / 4) : 1;
  localparam int CMPW = (TCW + 1 > DIM_W) ? TCW + 1 : DIM_W;
  localparam int XW   = TCW + 3;
  localparam int YW   = TCW + 2;

  logic [2:0]     inner_col_r, inner_col_nxt;
  logic [1:0]     inner_row_r, inner_row_nxt;
  logic [TCW-1:0] tile_col_r, tile_col_nxt;
  logic [TCW-1:0] tile_row_r, tile_row_nxt;

  logic [CMPW-1:0] w_ext, h_ext, w_max, h_max, wt, ht;
  logic [TCW-1:0]  wt_m1, ht_m1;
  logic            col_end, row_end, tc_end, tr_end;
  logic [XW-1:0]   x_full;
  logic [YW-1:0]   y_full;

  always_comb begin
    w_ext = CMPW'(width_tiles);
    h_ext = CMPW'(height_tiles);
    w_max = (fmt == FMT_RGB5A3) ? CMPW'(MAX_DIM / TILE_W_5A3) : CMPW'(MAX_DIM / TILE_W_CI8);
    h_max = CMPW'(MAX_DIM / TILE_H);
    if (w_ext == '0) begin
      wt = CMPW'(1);
    end else if (w_ext > w_max) begin
      wt = w_max;
    end else begin
      wt = w_ext;
    end
    if (h_ext == '0) begin
      ht = CMPW'(1);
    end else if (h_ext > h_max) begin
      ht = h_max;
    end else begin
      ht = h_ext;
    end
    wt_m1 = TCW'(wt - CMPW'(1));
    ht_m1 = TCW'(ht - CMPW'(1));
  end

  assign col_end = (fmt == FMT_RGB5A3) ? (inner_col_r >= 3'(TILE_W_5A3 - 1))
                                       : (inner_col_r >= 3'(TILE_W_CI8 - 1));
  assign row_end = (inner_row_r >= 2'(TILE_H - 1));
  assign tc_end  = (tile_col_r >= wt_m1);
  assign tr_end  = (tile_row_r >= ht_m1);

  always_comb begin
    if (fmt == FMT_RGB5A3) begin
      x_full = XW'({tile_col_r, 2'b00}) + XW'(inner_col_r[1:0]);
    end else begin
      x_full = XW'({tile_col_r, 3'b000}) + XW'(inner_col_r);
    end
    y_full = {tile_row_r, inner_row_r};
  end

  assign pos.x    = PIX_W'(x_full);
  assign pos.y    = PIX_W'(y_full);
  assign pos.last = col_end & row_end & tc_end & tr_end;

  always_comb begin
    inner_col_nxt = inner_col_r;
    inner_row_nxt = inner_row_r;
    tile_col_nxt  = tile_col_r;
    tile_row_nxt  = tile_row_r;
    if (clear) begin
      inner_col_nxt = '0;
      inner_row_nxt = '0;
      tile_col_nxt  = '0;
      tile_row_nxt  = '0;
    end else if (advance) begin
      if (!col_end) begin
        inner_col_nxt = inner_col_r + 3'd1;
      end else begin
        inner_col_nxt = '0;
        if (!row_end) begin
          inner_row_nxt = inner_row_r + 2'd1;
        end else begin
          inner_row_nxt = '0;
          if (!tc_end) begin
            tile_col_nxt = tile_col_r + TCW'(1);
          end else begin
            tile_col_nxt = '0;
            tile_row_nxt = tr_end ? '0 : tile_row_r + TCW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_col_r <= '0;
      inner_row_r <= '0;
      tile_col_r  <= '0;
      tile_row_r  <= '0;
    end else begin
      inner_col_r <= inner_col_nxt;
      inner_row_r <= inner_row_nxt;
      tile_col_r  <= tile_col_nxt;
      tile_row_r  <= tile_row_nxt;
    end
  end

endmodule

// ----- hw/rtl/ttla_palette.sv -----
// Palette memory of RGB5A3 colors with one write port and a registered read port.
`timescale 1ns / 1ps
module ttla_palette (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ttla_pkg::PAL_AW-1:0]  wr_addr,
  input  logic [ttla_pkg::WORD_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [ttla_pkg::PAL_AW-1:0]  rd_addr,
  output logic [ttla_pkg::WORD_W-1:0]  rd_data
);
  import ttla_pkg::*;

  logic [WORD_W-1:0] mem [PAL_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/ttla_expand.sv -----
// Expansion of one RGB5A3 word to an ARGB8888 color.
`timescale 1ns / 1ps
module ttla_expand (
  input  logic [ttla_pkg::WORD_W-1:0]  word,
  output logic [ttla_pkg::COLOR_W-1:0] color
);
  import ttla_pkg::*;

  logic [4:0] r5, g5, b5;
  logic [2:0] a3;
  logic [3:0] r4, g4, b4;

  always_comb begin
    r5 = word[14:10];
    g5 = word[9:5];
    b5 = word[4:0];
    a3 = word[14:12];
    r4 = word[11:8];
    g4 = word[7:4];
    b4 = word[3:0];
    if (word[15]) begin
      color = {8'hFF, r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
    end else begin
      color = {a3, a3, a3[2:1], r4, r4, g4, g4, b4, b4};
    end
  end

endmodule

// ----- hw/rtl/tiled_texture_to_linear_argb.sv -----
// Top level of the tiled texture to linear ARGB converter.
`timescale 1ns / 1ps
// The block takes one item per clock cycle unless the output stalls. A texel item goes first
// into the stage register with the registered read of the palette memory and the position
// counters, then through the color expansion into the output register. A palette item writes one
// palette entry and gives no result. Texels arrive in tile order; the image size and format are
// set through the configuration port, and any write to a register restarts the image at its
// first texel. The palette holds garbage after reset until it is loaded.
`include "tiled_texture_to_linear_argb_macros.svh"
module tiled_texture_to_linear_argb #(
  parameter int MAX_DIM = ttla_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttla_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [ttla_pkg::PAL_AW-1:0]    in_palette_slot,
  input  logic [ttla_pkg::WORD_W-1:0]    in_palette_word,
  input  logic [ttla_pkg::WORD_W-1:0]    in_texel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ttla_pkg::PIX_W-1:0]     out_pixel_x,
  output logic [ttla_pkg::PIX_W-1:0]     out_pixel_y,
  output logic [ttla_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                           out_last_pixel
);
  import ttla_pkg::*;

  logic               fmt_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic               cfg_wr, cfg_hit;

  logic               in_acc, tex_acc, pal_wr;
  logic               s1_adv;
  logic               s1_v_r;
  pos_t               pos, s1_pos_r;
  logic [WORD_W-1:0]  s1_texel_r;
  logic [WORD_W-1:0]  pal_rd;
  logic [WORD_W-1:0]  s1_word;
  logic [COLOR_W-1:0] s1_color;

  logic               out_valid_r;
  pos_t               out_pos_r;
  logic [COLOR_W-1:0] out_color_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_wr & ((cfg_index == CFG_FORMAT) || (cfg_index == CFG_WIDTH) ||
                               (cfg_index == CFG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_RGB5A3;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_FORMAT: fmt_r    <= cfg_data[0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid & in_ready;
  assign tex_acc  = in_acc & (in_func == FUNC_TEXEL);
  assign pal_wr   = in_acc & (in_func == FUNC_PALETTE);

  ttla_pos #(
    .MAX_DIM(MAX_DIM)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (cfg_hit),
    .advance      (tex_acc),
    .fmt          (fmt_r),
    .width_tiles  (width_r),
    .height_tiles (height_r),
    .pos          (pos)
  );

  ttla_palette u_palette (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (in_palette_slot),
    .wr_data (in_palette_word),
    .rd_en   (tex_acc),
    .rd_addr (in_texel[PAL_AW-1:0]),
    .rd_data (pal_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= tex_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tex_acc) begin
      s1_pos_r   <= pos;
      s1_texel_r <= in_texel;
    end
  end

  assign s1_word = (fmt_r == FMT_RGB5A3) ? s1_texel_r : pal_rd;

  ttla_expand u_expand (
    .word  (s1_word),
    .color (s1_color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_pos_r   <= s1_pos_r;
      out_color_r <= s1_color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pos_r.x;
  assign out_pixel_y     = out_pos_r.y;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_pos_r.last;

  `TTLA_ASSERT_NOW(a_stall_only_when_full, !in_ready, s1_v_r && out_valid_r && !out_ready)
  `TTLA_ASSERT_NEXT(a_texel_enters_stage, tex_acc, s1_v_r)
  `TTLA_ASSERT_NEXT(a_stage_holds_on_stall, s1_v_r && !s1_adv, s1_v_r && out_valid_r)
  `TTLA_ASSERT_NEXT(a_cfg_restarts_image, cfg_hit, pos.x == '0 && pos.y == '0)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the tiled texture to linear ARGB converter.
`timescale 1ns / 1ps
module testbench;
  import ttla_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic              func;
    logic [PAL_AW-1:0] slot;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] texel;
  } feed_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_func = FUNC_PALETTE;
  logic [PAL_AW-1:0] in_palette_slot = '0;
  logic [WORD_W-1:0] in_palette_word = '0;
  logic [WORD_W-1:0] in_texel = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   out_pixel_x;
  logic [PIX_W-1:0]   out_pixel_y;
  logic [COLOR_W-1:0] out_pixel_color;
  logic               out_last_pixel;

  tiled_texture_to_linear_argb u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_palette_slot (in_palette_slot),
    .in_palette_word (in_palette_word),
    .in_texel        (in_texel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  feed_item_t feed_q[$];
  pixel_t     pixel_q[$];
  int         err_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Converter state as the checker sees it.
  logic              cur_fmt = FMT_RGB5A3;
  logic [DIM_W-1:0]  cur_width = WIDTH_RST;
  logic [DIM_W-1:0]  cur_height = HEIGHT_RST;
  logic [2:0]        icol = '0;
  logic [1:0]        irow = '0;
  logic [7:0]        tcol = '0;
  logic [7:0]        trow = '0;
  logic [WORD_W-1:0] pal_mem [PAL_DEPTH];

  // Stimulus side: format in force and palette entries already loaded.
  logic              gen_fmt = FMT_RGB5A3;
  logic              slot_known [PAL_DEPTH];
  logic [PAL_AW-1:0] known_slots[$];

  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [COLOR_W-1:0] expand_rgb5a3(input logic [WORD_W-1:0] w);
    logic [7:0] a, r, g, b;
    if (w[15]) begin
      r = {w[14:10], w[14:12]};
      g = {w[9:5], w[9:7]};
      b = {w[4:0], w[4:2]};
      a = 8'hFF;
    end else begin
      a = {w[14:12], w[14:12], w[14:13]};
      r = {w[11:8], w[11:8]};
      g = {w[7:4], w[7:4]};
      b = {w[3:0], w[3:0]};
    end
    return {a, r, g, b};
  endfunction

  function automatic int clamp_tiles(input int v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  task automatic clear_position();
    icol = '0;
    irow = '0;
    tcol = '0;
    trow = '0;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    case (idx)
      CFG_FORMAT: begin
        cur_fmt = data[0];
        clear_position();
      end
      CFG_WIDTH: begin
        cur_width = data;
        clear_position();
      end
      CFG_HEIGHT: begin
        cur_height = data;
        clear_position();
      end
      default: begin
      end
    endcase
  endtask

  task automatic convert_item(input feed_item_t it);
    int tw, wt, ht, x, y;
    logic col_end, row_end, tc_end, tr_end;
    logic [WORD_W-1:0] src;
    pixel_t p;
    if (it.func == FUNC_PALETTE) begin
      pal_mem[it.slot] = it.word;
    end else begin
      tw = (cur_fmt == FMT_RGB5A3) ? TILE_W_5A3 : TILE_W_CI8;
      wt = clamp_tiles(int'(cur_width), MAX_DIM_DEF / tw);
      ht = clamp_tiles(int'(cur_height), MAX_DIM_DEF / TILE_H);
      src = (cur_fmt == FMT_RGB5A3) ? it.texel : pal_mem[it.texel[PAL_AW-1:0]];
      x = int'(tcol) * tw + int'(icol);
      y = int'(trow) * TILE_H + int'(irow);
      col_end = int'(icol) >= tw - 1;
      row_end = int'(irow) >= TILE_H - 1;
      tc_end = int'(tcol) >= wt - 1;
      tr_end = int'(trow) >= ht - 1;
      p.x = x[PIX_W-1:0];
      p.y = y[PIX_W-1:0];
      p.color = expand_rgb5a3(src);
      p.last = col_end && row_end && tc_end && tr_end;
      pixel_q.push_back(p);
      if (!col_end) begin
        icol = icol + 1'b1;
      end else begin
        icol = '0;
        if (!row_end) begin
          irow = irow + 1'b1;
        end else begin
          irow = '0;
          if (!tc_end) begin
            tcol = tcol + 1'b1;
          end else begin
            tcol = '0;
            if (!tr_end) trow = trow + 1'b1;
            else trow = '0;
          end
        end
      end
    end
  endtask

  // Driver: presents queued items and feeds every accepted one to the converter model.
  always @(posedge clk) begin : drive_proc
    feed_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it.func = in_func;
        it.slot = in_palette_slot;
        it.word = in_palette_word;
        it.texel = in_texel;
        convert_item(it);
      end
      if (!in_valid || in_ready) begin
        if (feed_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = feed_q.pop_front();
          in_valid <= 1'b1;
          in_func <= it.func;
          in_palette_slot <= it.slot;
          in_palette_word <= it.word;
          in_texel <= it.texel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: drives the result ready and checks each pixel against the oldest prediction.
  always @(posedge clk) begin : recv_proc
    pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          flag_error($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                               out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel));
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_x !== want.x)
            flag_error($sformatf("pixel_x got %0d want %0d", out_pixel_x, want.x));
          if (out_pixel_y !== want.y)
            flag_error($sformatf("pixel_y got %0d want %0d", out_pixel_y, want.y));
          if (out_pixel_color !== want.color)
            flag_error($sformatf("pixel_color got %h want %h", out_pixel_color, want.color));
          if (out_last_pixel !== want.last)
            flag_error($sformatf("last_pixel got %b want %b", out_last_pixel, want.last));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic push_item(input logic func, input logic [PAL_AW-1:0] slot,
                           input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] texel);
    feed_item_t it;
    it.func = func;
    it.slot = slot;
    it.word = word;
    it.texel = texel;
    if (func == FUNC_PALETTE && !slot_known[slot]) begin
      slot_known[slot] = 1'b1;
      known_slots.push_back(slot);
    end
    feed_q.push_back(it);
  endtask

  task automatic gen_items(input int count, input int pal_pct);
    logic [WORD_W-1:0] tex;
    for (int k = 0; k < count; k++) begin
      tex = 16'($urandom);
      if ($urandom_range(0, 99) < pal_pct) begin
        push_item(FUNC_PALETTE, 8'($urandom), 16'($urandom), tex);
      end else begin
        if (gen_fmt == FMT_CI8)
          tex[PAL_AW-1:0] = known_slots[$urandom_range(0, known_slots.size() - 1)];
        push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), tex);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (feed_q.size() != 0 || in_valid || pixel_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
    if (idx == CFG_FORMAT) gen_fmt = data[0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_image(input logic fmt, input int w, input int h);
    wait_drained();
    cfg_write(CFG_FORMAT, {8'($urandom), fmt});
    cfg_write(CFG_WIDTH, w[DIM_W-1:0]);
    cfg_write(CFG_HEIGHT, h[DIM_W-1:0]);
  endtask

  task automatic set_idle(input int s, input int r);
    send_idle_pct <= s;
    recv_idle_pct <= r;
  endtask

  initial begin
    for (int i = 0; i < PAL_DEPTH; i++) begin
      slot_known[i] = 1'b0;
      pal_mem[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(29, 56);

    // Reset settings: RGB5A3 texels at the channel extremes and both alpha modes, then palette loads.
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h0000);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'hFFFF);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h8000);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h7FFF);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h7000);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h0FFF);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'hAAAA);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h5555);
    push_item(FUNC_PALETTE, 8'd0, 16'hFFFF, 16'($urandom));
    push_item(FUNC_PALETTE, 8'd255, 16'h0000, 16'($urandom));
    push_item(FUNC_PALETTE, 8'd1, 16'h8000, 16'($urandom));
    push_item(FUNC_PALETTE, 8'd254, 16'h7FFF, 16'($urandom));
    wait_drained();

    // CI8 lookups with junk in the high texel byte, and a lookup right after its load.
    cfg_write(CFG_FORMAT, 9'h1FE);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'hFF00);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h00FF);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'hA501);
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h5AFE);
    push_item(FUNC_PALETTE, 8'd7, 16'h9C3A, 16'($urandom));
    push_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), 16'h3307);

    for (int p = 0; p < 12; p++) begin
      set_image(1'($urandom), $urandom_range(0, 3), $urandom_range(0, 3));
      if (p == 4) set_idle(56, 29);
      if (p == 8) set_idle(0, 0);
      gen_items(40, 15);
      if (p == 5 || p == 9) hold_token <= hold_token + 1;
      if (p == 6) begin
        // A write to an index past the register list must leave the position alone.
        wait_drained();
        cfg_write(CFG_UNUSED, 9'($urandom));
        gen_items(40, 15);
      end
    end

    // Size extremes: large sizes start an image, zero and unit sizes wrap into the next.
    set_image(FMT_RGB5A3, 256, 1);
    gen_items(120, 0);
    set_image(FMT_CI8, 511, 1);
    gen_items(120, 0);
    set_image(FMT_RGB5A3, 0, 0);
    gen_items(40, 0);
    set_image(FMT_RGB5A3, 1, 511);
    gen_items(120, 0);
    set_image(FMT_CI8, 1, 1);
    gen_items(120, 10);

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
